// ===== rtl/core/hsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsm_pkg
// Shared types, op codes and widths for the heap and stack memory unit.
// ----------------------------------------------------------------------------
package hsm_pkg;

    // Default store size in bytes
    localparam int STORE_BYTES_DEF = 1024;

    // Field widths of the command and result words
    localparam int OP_W    = 4;
    localparam int AMT_W   = 16;
    localparam int WORD_W  = 32;
    localparam int BYTE_W  = 8;
    localparam int OFFS_W  = 11;
    localparam int ERR_W   = 3;
    localparam int DEPTH_W = 9;

    // Op codes
    localparam logic [OP_W-1:0] OP_ALLOC      = 4'd0;
    localparam logic [OP_W-1:0] OP_HEAP_RESET = 4'd1;
    localparam logic [OP_W-1:0] OP_PUSH       = 4'd2;
    localparam logic [OP_W-1:0] OP_POP        = 4'd3;
    localparam logic [OP_W-1:0] OP_STK_RESET  = 4'd4;
    localparam logic [OP_W-1:0] OP_DISCARD    = 4'd5;
    localparam logic [OP_W-1:0] OP_READ       = 4'd6;
    localparam logic [OP_W-1:0] OP_WRITE      = 4'd7;
    localparam logic [OP_W-1:0] OP_SET_DEPTH  = 4'd8;
    localparam logic [OP_W-1:0] OP_CHECK      = 4'd9;

    // Error flag bits
    localparam logic [ERR_W-1:0] ERR_NONE   = 3'b000;
    localparam logic [ERR_W-1:0] ERR_ACCESS = 3'b001;
    localparam logic [ERR_W-1:0] ERR_OVER   = 3'b010;
    localparam logic [ERR_W-1:0] ERR_UNDER  = 3'b100;

    // Store work an op needs after it is taken
    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_FILL  = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_READ  = 2'd3
    } kind_t;

    // Controller states
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_FILL   = 5'b00010,
        ST_WRITE  = 5'b00100,
        ST_READ   = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic step;
        logic finish;
    } hsm_cmd_t;

    // Datapath to controller
    typedef struct packed {
        kind_t kind;
        logic  last;
    } hsm_status_t;

endpackage

// ===== rtl/core/hsm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module hsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/hsm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsm_ctrl
// Sequencer: takes a command word, runs the byte steps of the store, and
// closes each op with one finish cycle that loads the result word.
// ----------------------------------------------------------------------------
module hsm_ctrl
    import hsm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  hsm_status_t status,
    output hsm_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    case (status.kind)
                        KIND_FILL:  state_next = ST_FILL;
                        KIND_WRITE: state_next = ST_WRITE;
                        KIND_READ:  state_next = ST_READ;
                        default:    state_next = ST_FINISH;
                    endcase
                end
            end
            ST_FILL, ST_WRITE, ST_READ:
            begin
                cmd.step = 1'b1;
                if (status.last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== rtl/core/hsm_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsm_dp
// Datapath: heap and stack pointers, op decode, byte store access and the
// result word registers.
// ----------------------------------------------------------------------------
module hsm_dp
    import hsm_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  hsm_cmd_t            cmd,
    output hsm_status_t         status,
    input  logic [OP_W-1:0]     op,
    input  logic [AMT_W-1:0]    amount,
    input  logic [WORD_W-1:0]   data_in,
    output logic                done,
    output logic [WORD_W-1:0]   data_out,
    output logic [OFFS_W-1:0]   alloc_offset,
    output logic                ok,
    output logic [ERR_W-1:0]    error_flags,
    output logic [OFFS_W-1:0]   heap_used,
    output logic [DEPTH_W-1:0]  stack_depth,
    output logic [OFFS_W-1:0]   free_bytes
);

    localparam int ADDR_W = $clog2(STORE_BYTES);
    localparam int PW     = ADDR_W + 1;
    localparam int EW     = ((PW > AMT_W) ? PW : AMT_W) + 3;

    // Pointers and per-op registers
    logic [PW-1:0]     heap_reg;
    logic [PW-1:0]     top_reg;
    logic [PW-1:0]     base_reg;
    logic [PW-1:0]     cnt_reg;
    logic [PW-1:0]     limit_reg;
    kind_t             kind_reg;
    logic [WORD_W-1:0] din_reg;
    logic [WORD_W-1:0] word_reg;
    logic              ok_pend_reg;
    logic [ERR_W-1:0]  err_pend_reg;
    logic [PW-1:0]     offs_pend_reg;

    // Result word registers
    logic               done_reg;
    logic [WORD_W-1:0]  data_out_reg;
    logic [OFFS_W-1:0]  offs_out_reg;
    logic               ok_out_reg;
    logic [ERR_W-1:0]   err_out_reg;
    logic [OFFS_W-1:0]  heap_out_reg;
    logic [DEPTH_W-1:0] depth_out_reg;
    logic [OFFS_W-1:0]  free_out_reg;

    // Extended views
    logic [EW-1:0] sb_e;
    logic [EW-1:0] heap_e;
    logic [EW-1:0] top_e;
    logic [EW-1:0] amt_e;
    logic [EW-1:0] amt4_e;
    logic [EW-1:0] depth_e;
    logic [EW-1:0] free_e;

    // Decode results
    logic          dec_ok;
    logic [ERR_W-1:0] dec_err;
    kind_t         dec_kind;
    logic [EW-1:0] dec_base;
    logic [EW-1:0] dec_limit;
    logic [EW-1:0] dec_heap;
    logic [EW-1:0] dec_top;
    logic [EW-1:0] dec_offs;

    // Store port
    logic              mem_we;
    logic              mem_re;
    logic [PW-1:0]     mem_addr_full;
    logic [ADDR_W-1:0] mem_addr;
    logic [BYTE_W-1:0] mem_wdata;
    logic [BYTE_W-1:0] mem_rdata;

    assign sb_e    = EW'(STORE_BYTES);
    assign heap_e  = EW'(heap_reg);
    assign top_e   = EW'(top_reg);
    assign amt_e   = EW'(amount);
    assign amt4_e  = amt_e << 2;
    assign depth_e = (sb_e - top_e) >> 2;
    assign free_e  = top_e - heap_e;

    // Decode the incoming command word against the current pointers
    always_comb
    begin
        dec_ok    = 1'b0;
        dec_err   = ERR_NONE;
        dec_kind  = KIND_NONE;
        dec_base  = '0;
        dec_limit = '0;
        dec_heap  = heap_e;
        dec_top   = top_e;
        dec_offs  = '0;
        case (op)
            OP_ALLOC:
            begin
                if (amount != '0 && (heap_e + amt_e) <= top_e)
                begin
                    dec_ok    = 1'b1;
                    dec_kind  = KIND_FILL;
                    dec_base  = heap_e;
                    dec_limit = amt_e - EW'(1);
                    dec_offs  = heap_e;
                    dec_heap  = heap_e + amt_e;
                end
            end
            OP_HEAP_RESET:
            begin
                dec_ok   = 1'b1;
                dec_heap = '0;
            end
            OP_PUSH:
            begin
                if (free_e < EW'(4))
                begin
                    dec_err = ERR_OVER;
                end
                else
                begin
                    dec_ok    = 1'b1;
                    dec_kind  = KIND_WRITE;
                    dec_top   = top_e - EW'(4);
                    dec_base  = top_e - EW'(4);
                    dec_limit = EW'(3);
                end
            end
            OP_POP:
            begin
                if (depth_e == '0)
                begin
                    dec_err = ERR_UNDER;
                end
                else
                begin
                    dec_ok    = 1'b1;
                    dec_kind  = KIND_READ;
                    dec_base  = top_e;
                    dec_top   = top_e + EW'(4);
                    dec_limit = EW'(4);
                end
            end
            OP_STK_RESET:
            begin
                dec_ok  = 1'b1;
                dec_top = sb_e;
            end
            OP_DISCARD:
            begin
                if (amt_e > depth_e)
                begin
                    dec_err = ERR_UNDER;
                    dec_top = sb_e;
                end
                else
                begin
                    dec_ok  = 1'b1;
                    dec_top = top_e + amt4_e;
                end
            end
            OP_READ:
            begin
                if (amt_e >= depth_e)
                begin
                    dec_err = ERR_ACCESS;
                end
                else
                begin
                    dec_ok    = 1'b1;
                    dec_kind  = KIND_READ;
                    dec_base  = sb_e - amt4_e - EW'(4);
                    dec_limit = EW'(4);
                end
            end
            OP_WRITE:
            begin
                if (amt_e >= depth_e)
                begin
                    dec_err = ERR_ACCESS;
                end
                else
                begin
                    dec_ok    = 1'b1;
                    dec_kind  = KIND_WRITE;
                    dec_base  = sb_e - amt4_e - EW'(4);
                    dec_limit = EW'(3);
                end
            end
            OP_SET_DEPTH:
            begin
                if (amt4_e > sb_e || (sb_e - amt4_e) < heap_e)
                begin
                    dec_err = ERR_OVER;
                end
                else
                begin
                    dec_ok  = 1'b1;
                    dec_top = sb_e - amt4_e;
                end
            end
            OP_CHECK:
            begin
                if (amt_e > top_e)
                begin
                    dec_err = ERR_ACCESS;
                end
                else
                begin
                    dec_ok = 1'b1;
                end
            end
            default:
            begin
                dec_ok = 1'b0;
            end
        endcase
    end

    assign status.kind = dec_kind;
    assign status.last = (cnt_reg == limit_reg);

    // Store access for the current byte step
    assign mem_addr_full = base_reg + cnt_reg;
    assign mem_addr      = mem_addr_full[ADDR_W-1:0];
    assign mem_we        = cmd.step && (kind_reg == KIND_FILL || kind_reg == KIND_WRITE);
    assign mem_re        = cmd.step && (kind_reg == KIND_READ) && (cnt_reg < PW'(4));
    assign mem_wdata     = (kind_reg == KIND_WRITE) ?
                           din_reg[{cnt_reg[1:0], 3'b000} +: BYTE_W] : '0;

    hsm_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_addr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_addr),
        .rdata (mem_rdata)
    );

    // Pointers: update when a command word is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_reg <= '0;
            top_reg  <= PW'(STORE_BYTES);
            kind_reg <= KIND_NONE;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.accept)
            begin
                heap_reg <= dec_heap[PW-1:0];
                top_reg  <= dec_top[PW-1:0];
                kind_reg <= dec_kind;
                cnt_reg  <= '0;
            end
            else if (cmd.step)
            begin
                cnt_reg <= cnt_reg + PW'(1);
            end
        end
    end

    // Per-op payload: latch at accept, gather read bytes
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            base_reg      <= dec_base[PW-1:0];
            limit_reg     <= dec_limit[PW-1:0];
            din_reg       <= data_in;
            ok_pend_reg   <= dec_ok;
            err_pend_reg  <= dec_err;
            offs_pend_reg <= dec_offs[PW-1:0];
            word_reg      <= '0;
        end
        else if (cmd.step && kind_reg == KIND_READ && cnt_reg != '0)
        begin
            word_reg <= {mem_rdata, word_reg[WORD_W-1:BYTE_W]};
        end
    end

    // Load the result word
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            data_out_reg  <= (kind_reg == KIND_READ) ? word_reg : '0;
            offs_out_reg  <= OFFS_W'(offs_pend_reg);
            ok_out_reg    <= ok_pend_reg;
            err_out_reg   <= err_pend_reg;
            heap_out_reg  <= heap_e[OFFS_W-1:0];
            depth_out_reg <= depth_e[DEPTH_W-1:0];
            free_out_reg  <= free_e[OFFS_W-1:0];
        end
    end

    assign done         = done_reg;
    assign data_out     = data_out_reg;
    assign alloc_offset = offs_out_reg;
    assign ok           = ok_out_reg;
    assign error_flags  = err_out_reg;
    assign heap_used    = heap_out_reg;
    assign stack_depth  = depth_out_reg;
    assign free_bytes   = free_out_reg;

endmodule

// ===== rtl/core/heap_and_stack_memory_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heap_and_stack_memory_unit
// Byte store shared by an upward bump allocator and a downward word stack.
// ----------------------------------------------------------------------------
// From start to done strobe, ops without store access go straight to the
// finish state; push and write, pop and read, and alloc first step through
// their store bytes. The byte-wide store port takes one byte per cycle and
// its read data is registered. busy drops in the cycle done is high, so
// a new word can be taken then. Reset empties heap and stack at once;
// the store contents are not cleared and no clearing pass runs.
module heap_and_stack_memory_unit
    import hsm_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [OP_W-1:0]    op,
    input  logic [AMT_W-1:0]   amount,
    input  logic [WORD_W-1:0]  data_in,
    output logic               done,
    output logic [WORD_W-1:0]  data_out,
    output logic [OFFS_W-1:0]  alloc_offset,
    output logic               ok,
    output logic [ERR_W-1:0]   error_flags,
    output logic [OFFS_W-1:0]  heap_used,
    output logic [DEPTH_W-1:0] stack_depth,
    output logic [OFFS_W-1:0]  free_bytes
);

    hsm_cmd_t    cmd;
    hsm_status_t status;

    hsm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    hsm_dp #(
        .STORE_BYTES (STORE_BYTES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .op           (op),
        .amount       (amount),
        .data_in      (data_in),
        .done         (done),
        .data_out     (data_out),
        .alloc_offset (alloc_offset),
        .ok           (ok),
        .error_flags  (error_flags),
        .heap_used    (heap_used),
        .stack_depth  (stack_depth),
        .free_bytes   (free_bytes)
    );

    // A taken word always leaves the idle state
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    // The result strobe comes only once the sequencer is back to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // The strobe lasts one cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // A successful op carries no error flags
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && ok) |-> (error_flags == ERR_NONE))
        else $error("ok with error flags set");

endmodule

// ===== sim/heap_and_stack_memory_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heap_and_stack_memory_unit_tb
// Drives heap and stack op words through the start/busy handshake and checks
// every done strobe against an in-bench model of the byte store, the bump
// allocator and the word stack. Stimulus is a short directed sweep of the
// corner cases, then random op mixes with random idle gaps in all but the second.
// ----------------------------------------------------------------------------
module heap_and_stack_memory_unit_tb;
    import hsm_pkg::*;

    localparam int BYTES       = STORE_BYTES_DEF;
    localparam int CHUNKS      = 4;
    localparam int CHUNK_ITEMS = 335;
    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int MAX_LINES   = 50;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [AMT_W-1:0]  amt;
        logic [WORD_W-1:0] word;
    } mem_cmd_t;

    typedef struct packed {
        logic [WORD_W-1:0]  data;
        logic [OFFS_W-1:0]  offs;
        logic               ok;
        logic [ERR_W-1:0]   err;
        logic [OFFS_W-1:0]  heap;
        logic [DEPTH_W-1:0] depth;
        logic [OFFS_W-1:0]  free;
    } mem_outcome_t;

    logic               clk     = 1'b0;
    logic               rst_n   = 1'b0;
    logic               start   = 1'b0;
    logic [OP_W-1:0]    op      = OP_ALLOC;
    logic [AMT_W-1:0]   amount  = '0;
    logic [WORD_W-1:0]  data_in = '0;
    logic               busy;
    logic               done;
    logic [WORD_W-1:0]  data_out;
    logic [OFFS_W-1:0]  alloc_offset;
    logic               ok;
    logic [ERR_W-1:0]   error_flags;
    logic [OFFS_W-1:0]  heap_used;
    logic [DEPTH_W-1:0] stack_depth;
    logic [OFFS_W-1:0]  free_bytes;

    // Model state of the store, the heap end and the stack top
    logic [7:0]  byte_img [BYTES];
    int unsigned heap_next = 0;
    int unsigned top_ptr   = BYTES;

    mem_cmd_t     cmd_backlog[$];
    mem_outcome_t pending_outcomes[$];
    int           mismatches = 0;
    int           cycles     = 0;
    int           gap_left   = 0;
    bit           gaps_on    = 1'b1;

    heap_and_stack_memory_unit #(
        .STORE_BYTES(BYTES)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .amount      (amount),
        .data_in     (data_in),
        .done        (done),
        .data_out    (data_out),
        .alloc_offset(alloc_offset),
        .ok          (ok),
        .error_flags (error_flags),
        .heap_used   (heap_used),
        .stack_depth (stack_depth),
        .free_bytes  (free_bytes)
    );

    always #5 clk = ~clk;

    // Fetch a little-endian word from the model store
    function automatic logic [WORD_W-1:0] load_word(input int unsigned addr);
        return {byte_img[addr + 3], byte_img[addr + 2], byte_img[addr + 1], byte_img[addr]};
    endfunction

    // Place a little-endian word into the model store
    function automatic void store_word(input int unsigned addr, input logic [WORD_W-1:0] w);
        byte_img[addr]     = w[7:0];
        byte_img[addr + 1] = w[15:8];
        byte_img[addr + 2] = w[23:16];
        byte_img[addr + 3] = w[31:24];
    endfunction

    // Apply one op to the model and return the result word it yields
    function automatic mem_outcome_t mem_op_outcome(input logic [OP_W-1:0] c_op,
                                                    input logic [AMT_W-1:0] c_amt,
                                                    input logic [WORD_W-1:0] c_word);
        mem_outcome_t r;
        int unsigned  a;
        int unsigned  depth;
        int unsigned  i;
        r     = '0;
        a     = c_amt;
        depth = (BYTES - top_ptr) / 4;
        case (c_op)
            OP_ALLOC: begin
                if (a != 0 && heap_next + a <= top_ptr) begin
                    for (i = 0; i < a; i++)
                        byte_img[heap_next + i] = 8'h00;
                    r.offs    = OFFS_W'(heap_next);
                    heap_next = heap_next + a;
                    r.ok      = 1'b1;
                end
            end
            OP_HEAP_RESET: begin
                heap_next = 0;
                r.ok      = 1'b1;
            end
            OP_PUSH: begin
                if (top_ptr - heap_next < 4) begin
                    r.err = ERR_OVER;
                end
                else begin
                    top_ptr = top_ptr - 4;
                    store_word(top_ptr, c_word);
                    r.ok = 1'b1;
                end
            end
            OP_POP: begin
                if (depth == 0) begin
                    r.err = ERR_UNDER;
                end
                else begin
                    r.data  = load_word(top_ptr);
                    top_ptr = top_ptr + 4;
                    r.ok    = 1'b1;
                end
            end
            OP_STK_RESET: begin
                top_ptr = BYTES;
                r.ok    = 1'b1;
            end
            OP_DISCARD: begin
                // Over-discard empties the stack and still flags underflow
                if (a > depth) begin
                    top_ptr = BYTES;
                    r.err   = ERR_UNDER;
                end
                else begin
                    top_ptr = top_ptr + 4 * a;
                    r.ok    = 1'b1;
                end
            end
            OP_READ: begin
                if (a >= depth) begin
                    r.err = ERR_ACCESS;
                end
                else begin
                    r.data = load_word(BYTES - 4 * (a + 1));
                    r.ok   = 1'b1;
                end
            end
            OP_WRITE: begin
                if (a >= depth) begin
                    r.err = ERR_ACCESS;
                end
                else begin
                    store_word(BYTES - 4 * (a + 1), c_word);
                    r.ok = 1'b1;
                end
            end
            OP_SET_DEPTH: begin
                if (4 * a > BYTES || BYTES - 4 * a < heap_next) begin
                    r.err = ERR_OVER;
                end
                else begin
                    top_ptr = BYTES - 4 * a;
                    r.ok    = 1'b1;
                end
            end
            OP_CHECK: begin
                if (a > top_ptr)
                    r.err = ERR_ACCESS;
                else
                    r.ok = 1'b1;
            end
            default: ;
        endcase
        r.heap  = OFFS_W'(heap_next);
        r.depth = DEPTH_W'((BYTES - top_ptr) / 4);
        r.free  = OFFS_W'(top_ptr - heap_next);
        return r;
    endfunction

    // Print one mismatch line, up to a cap, and count it
    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatches < MAX_LINES)
            $display("%0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic queue_cmd(input logic [OP_W-1:0] c_op, input int c_amt,
                             input logic [WORD_W-1:0] c_word);
        mem_cmd_t c;
        c.op   = c_op;
        c.amt  = AMT_W'(c_amt);
        c.word = c_word;
        cmd_backlog.push_back(c);
    endtask

    // Hold until every queued word is taken and every result has come back
    task automatic wait_drain();
        while (cmd_backlog.size() != 0 || start || pending_outcomes.size() != 0)
            @(negedge clk);
    endtask

    // Drive command words; predict each one at the edge that takes it
    always @(posedge clk) begin : drive_proc
        mem_cmd_t nxt;
        int       g;
        bit       taken;
        if (!rst_n) begin
            start <= 1'b0;
        end
        else begin
            taken = start && !busy;
            if (taken)
                pending_outcomes.push_back(mem_op_outcome(op, amount, data_in));
            if (!start || taken) begin
                if (gap_left != 0) begin
                    start    <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (cmd_backlog.size() != 0) begin
                    nxt     = cmd_backlog.pop_front();
                    start   <= 1'b1;
                    op      <= nxt.op;
                    amount  <= nxt.amt;
                    data_in <= nxt.word;
                    g = $urandom_range(0, 99);
                    if (!gaps_on || g < 70)
                        gap_left <= 0;
                    else if (g < 92)
                        gap_left <= $urandom_range(1, 3);
                    else
                        gap_left <= $urandom_range(8, 40);
                end
                else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Compare each result word with the oldest prediction
    always @(posedge clk) begin : check_proc
        mem_outcome_t want;
        if (rst_n && done) begin
            if (pending_outcomes.size() == 0) begin
                flag_mismatch("result with nothing pending", '0, '0);
            end
            else begin
                want = pending_outcomes.pop_front();
                if (data_out !== want.data)
                    flag_mismatch("data_out", data_out, want.data);
                if (alloc_offset !== want.offs)
                    flag_mismatch("alloc_offset", alloc_offset, want.offs);
                if (ok !== want.ok)
                    flag_mismatch("ok", ok, want.ok);
                if (error_flags !== want.err)
                    flag_mismatch("error_flags", error_flags, want.err);
                if (heap_used !== want.heap)
                    flag_mismatch("heap_used", heap_used, want.heap);
                if (stack_depth !== want.depth)
                    flag_mismatch("stack_depth", stack_depth, want.depth);
                if (free_bytes !== want.free)
                    flag_mismatch("free_bytes", free_bytes, want.free);
            end
        end
    end

    // Bound the run
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : stim_proc
        int               chunk;
        int               n;
        int               roll;
        int               pick;
        int               push_w;
        int               c_amt;
        logic [OP_W-1:0]  c_op;

        // Zero the whole store first so no later read hits an unwritten byte
        queue_cmd(OP_ALLOC, BYTES, '0);
        queue_cmd(OP_PUSH, 0, 32'hFFFF_FFFF);     // no room left: overflow
        queue_cmd(OP_ALLOC, 1, '0);               // heap full: refused
        queue_cmd(OP_CHECK, BYTES, '0);           // offset at the stack top
        queue_cmd(OP_CHECK, BYTES + 1, '0);       // just past it
        queue_cmd(OP_HEAP_RESET, 0, '0);
        queue_cmd(OP_ALLOC, 0, '0);               // zero size: refused
        queue_cmd(OP_ALLOC, 16'hFFFF, '0);        // too large: refused
        queue_cmd(OP_POP, 0, '0);                 // empty stack: underflow
        queue_cmd(OP_PUSH, 0, 32'hFFFF_FFFF);
        queue_cmd(OP_PUSH, 0, 32'h0000_0000);
        queue_cmd(OP_PUSH, 0, 32'hA5A5_5A5A);
        queue_cmd(OP_READ, 0, '0);
        queue_cmd(OP_READ, 3, '0);                // index at depth
        queue_cmd(OP_WRITE, 1, 32'h1234_5678);
        queue_cmd(OP_READ, 1, '0);
        queue_cmd(OP_DISCARD, 1, '0);
        queue_cmd(OP_POP, 0, '0);
        queue_cmd(OP_DISCARD, 16'hFFFF, '0);      // more than depth: emptied
        queue_cmd(OP_SET_DEPTH, BYTES / 4, '0);   // whole store as stack
        queue_cmd(OP_PUSH, 0, 32'h5A5A_A5A5);     // overflow
        queue_cmd(OP_READ, BYTES / 4 - 1, '0);
        queue_cmd(OP_SET_DEPTH, BYTES / 4 + 1, '0);
        queue_cmd(OP_STK_RESET, 0, '0);
        queue_cmd(OP_ALLOC, 16, '0);
        queue_cmd(OP_SET_DEPTH, BYTES / 4 - 1, '0); // would overlap the heap
        queue_cmd(OP_CHECK, 16'hFFFF, '0);
        queue_cmd(4'hF, 16'hFFFF, 32'hFFFF_FFFF);   // unknown op

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        wait_drain();

        // Random op mixes; push/pop balance shifts per chunk to swing depth
        for (chunk = 0; chunk < CHUNKS; chunk++) begin
            gaps_on = (chunk != 1);
            push_w  = 30 - 5 * chunk;
            for (n = 0; n < CHUNK_ITEMS; n++) begin
                roll  = $urandom_range(0, 99);
                pick  = $urandom_range(0, 99);
                c_amt = $urandom_range(0, 16'hFFFF);
                if (roll < push_w)
                    c_op = OP_PUSH;
                else if (roll < 40)
                    c_op = OP_POP;
                else if (roll < 52)
                    c_op = OP_READ;
                else if (roll < 62)
                    c_op = OP_WRITE;
                else if (roll < 74)
                    c_op = OP_ALLOC;
                else if (roll < 79)
                    c_op = OP_DISCARD;
                else if (roll < 86)
                    c_op = OP_SET_DEPTH;
                else if (roll < 92)
                    c_op = OP_CHECK;
                else if (roll < 95)
                    c_op = OP_HEAP_RESET;
                else if (roll < 98)
                    c_op = OP_STK_RESET;
                else
                    c_op = OP_W'($urandom_range(int'(OP_CHECK) + 1, (1 << OP_W) - 1));
                case (c_op)
                    OP_ALLOC: begin
                        if (pick < 90)
                            c_amt = $urandom_range(1, 48);
                        else if (pick < 97)
                            c_amt = $urandom_range(49, BYTES);
                        else if (pick == 97)
                            c_amt = 0;
                        else
                            c_amt = $urandom_range(BYTES + 1, 16'hFFFF);
                    end
                    OP_READ, OP_WRITE: begin
                        if (pick < 80)
                            c_amt = $urandom_range(0, 7);
                        else if (pick < 92)
                            c_amt = $urandom_range(0, BYTES / 4 + 4);
                    end
                    OP_DISCARD: begin
                        if (pick < 80)
                            c_amt = $urandom_range(0, 3);
                        else if (pick < 92)
                            c_amt = $urandom_range(4, 300);
                    end
                    OP_SET_DEPTH: begin
                        if (pick < 70)
                            c_amt = $urandom_range(0, 48);
                        else if (pick < 92)
                            c_amt = $urandom_range(49, BYTES / 4 + 4);
                    end
                    OP_CHECK: begin
                        if (pick < 60)
                            c_amt = $urandom_range(0, BYTES + 76);
                    end
                    default: ;
                endcase
                queue_cmd(c_op, c_amt, $urandom);
            end
            wait_drain();
        end

        // Let any stray strobe show up before the verdict
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_outcomes.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
